/* design/u8d_pkg.sv */
// Shared types and constants of the UTF-8 stream decoder.
package u8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned PEND_W = 2;

  // Lead byte classes: mask, expected pattern and payload bits.
  localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD2_DATA = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_DATA = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_DATA = 8'h07;

  // Continuation bytes are 10xxxxxx.
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;
  localparam logic [BYTE_W-1:0] CONT_DATA  = 8'h3F;
  localparam int unsigned       CONT_BITS  = 6;

  // Continuation bytes still expected after each lead byte class.
  localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
  localparam logic [PEND_W-1:0] PEND_LAST  = 2'd1;
  localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
  localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            bad_sequence;
    logic            string_end;
  } result_t;

endpackage

/* design/u8d_if.sv */
// Stream interfaces for raw bytes in and decoded code points out.
interface u8d_byte_if;
  import u8d_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u8d_point_if;
  import u8d_pkg::*;

  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            bad_sequence;
  logic            string_end;

  modport source (output valid, output code_point, output bad_sequence,
                  output string_end, input ready);
  modport sink   (input valid, input code_point, input bad_sequence,
                  input string_end, output ready);
endinterface

/* design/utf8_stream_decoder.sv */
// UTF-8 stream decoder: bytes in, code points out.
//
// The decoder takes one byte per clock while raw.ready is high and registers
// the code point of the byte that completes it. A string that held a stray
// or bad continuation byte, a lead byte of F8 or above, or that ends inside
// a sequence gives no code points after the fault and one result with
// bad_sequence set on its last byte. The result path has two registers, so
// the input keeps taking bytes for one more result while the output is
// stalled; raw.ready drops only when both hold a result. Throughput is one
// byte per cycle unless stalled, set by the combinational decode of the
// byte against the pending-sequence registers. No overlong or surrogate check.
module utf8_stream_decoder (
  input  logic         clk,
  input  logic         rst,
  u8d_byte_if.sink     raw,
  u8d_point_if.source  decoded
);
  import u8d_pkg::*;

  // Decoder state.
  logic [PEND_W-1:0] bytes_pending;
  logic [CP_W-1:0]   partial_value;
  logic              error_seen;

  logic [PEND_W-1:0] bytes_pending_next;
  logic [CP_W-1:0]   partial_value_next;
  logic              error_seen_next;

  // Result registers: head drives the port, skid catches one more result.
  result_t head;
  logic    head_valid;
  result_t skid;
  logic    skid_valid;

  logic            accept;
  logic            pop;
  logic            push;
  logic            have_cp;
  logic [CP_W-1:0] cp;
  logic [CP_W-1:0] shifted;
  logic            bad;
  result_t         result;

  assign raw.ready = !skid_valid;
  assign accept    = raw.valid && raw.ready;
  assign pop       = head_valid && decoded.ready;

  // Decode one byte against the pending sequence.
  assign shifted = {partial_value[CP_W-CONT_BITS-1:0],
                    raw.in_byte[CONT_BITS-1:0]};

  always_comb begin
    bytes_pending_next = bytes_pending;
    partial_value_next = partial_value;
    error_seen_next    = error_seen;
    have_cp            = 1'b0;
    cp                 = '0;
    if (!error_seen) begin
      if (bytes_pending == PEND_NONE) begin
        priority if ((raw.in_byte & ASCII_MASK) == '0) begin
          cp      = CP_W'(raw.in_byte);
          have_cp = 1'b1;
        end else if ((raw.in_byte & LEAD2_MASK) == LEAD2_CODE) begin
          partial_value_next = CP_W'(raw.in_byte & LEAD2_DATA);
          bytes_pending_next = PEND_LAST;
        end else if ((raw.in_byte & LEAD3_MASK) == LEAD3_CODE) begin
          partial_value_next = CP_W'(raw.in_byte & LEAD3_DATA);
          bytes_pending_next = PEND_TWO;
        end else if ((raw.in_byte & LEAD4_MASK) == LEAD4_CODE) begin
          partial_value_next = CP_W'(raw.in_byte & LEAD4_DATA);
          bytes_pending_next = PEND_THREE;
        end else begin
          error_seen_next = 1'b1;
        end
      end else if ((raw.in_byte & CONT_MASK) != CONT_CODE) begin
        error_seen_next = 1'b1;
      end else begin
        bytes_pending_next = bytes_pending - PEND_LAST;
        if (bytes_pending == PEND_LAST) begin
          cp                 = shifted;
          have_cp            = 1'b1;
          partial_value_next = '0;
        end else begin
          partial_value_next = shifted;
        end
      end
    end
  end

  // Form the result of this byte, if it has one.
  assign bad  = error_seen_next || (bytes_pending_next != PEND_NONE);
  assign push = accept && (have_cp || raw.end_of_string);

  always_comb begin
    result.code_point   = (raw.end_of_string && bad) ? '0 : cp;
    result.bad_sequence = raw.end_of_string && bad;
    result.string_end   = raw.end_of_string;
  end

  // State update; the last byte of a string clears everything.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending <= PEND_NONE;
      partial_value <= '0;
      error_seen    <= 1'b0;
    end else if (accept) begin
      if (raw.end_of_string) begin
        bytes_pending <= PEND_NONE;
        partial_value <= '0;
        error_seen    <= 1'b0;
      end else begin
        bytes_pending <= bytes_pending_next;
        partial_value <= partial_value_next;
        error_seen    <= error_seen_next;
      end
    end
  end

  // Two-entry result queue: head first, skid behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop || !head_valid) begin
        if (skid_valid) begin
          head_valid <= 1'b1;
          skid_valid <= push;
        end else begin
          head_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !head_valid) begin
      if (skid_valid) begin
        head <= skid;
        if (push) begin
          skid <= result;
        end
      end else if (push) begin
        head <= result;
      end
    end else if (push) begin
      skid <= result;
    end
  end

  assign decoded.valid        = head_valid;
  assign decoded.code_point   = head.code_point;
  assign decoded.bad_sequence = head.bad_sequence;
  assign decoded.string_end   = head.string_end;

  // The skid register only fills behind a held head result.
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("skid register holds a result while the head is empty");

  // An error result always closes a string and carries no code point.
  a_bad_closes_string: assert property (@(posedge clk) disable iff (rst)
    (head_valid && head.bad_sequence) |-> (head.string_end && head.code_point == '0))
    else $error("error result without string end or with a code point");

  // The last byte of a string leaves the decoder with nothing pending.
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (accept && raw.end_of_string) |=> (bytes_pending == PEND_NONE && !error_seen))
    else $error("decoder state not cleared after end of string");

  // After an error no state is gathered until the string ends.
  a_error_holds: assert property (@(posedge clk) disable iff (rst)
    (error_seen && !(accept && raw.end_of_string)) |=> error_seen)
    else $error("sticky error dropped inside a string");

endmodule
